@@ hw/rtl/lispt_pkg.sv @@
// Shared types and constants for the patience-sorting LIS length block.
`default_nettype none

package lispt_pkg;

   localparam int VALUE_W          = 32;
   localparam int LENGTH_W         = 9;
   localparam int CAPACITY_DEFAULT = 256;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      first;
   } req_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      logic                overflow;
   } rsp_type;

   // Status handed from one cell to the next one up the row.
   typedef struct packed {
      logic valid;  // the cell holds a live tail
      logic ge;     // the live tail is greater than or equal to the key
   } link_type;

endpackage

`default_nettype wire

@@ hw/rtl/lis_length_patience_tails_top.sv @@
// Top level of the longest-increasing-subsequence length block (patience tails).
// The result for an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle; every tail cell compares the key in parallel.
// A stalled result holds the output register, and the input stalls only then.
// Reset clears the run length and the output valid; tail contents are left as they are.
`default_nettype none

module lis_length_patience_tails_top #(
   parameter int CAPACITY = lispt_pkg::CAPACITY_DEFAULT
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  lispt_pkg::req_type req_item,
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output lispt_pkg::rsp_type       rsp_item
);

   localparam int               LEN_W = $clog2(CAPACITY + 1);
   localparam int               EXT_W = LEN_W + lispt_pkg::LENGTH_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);
   localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

   // The run length counts live tails; cells below it are valid.
   logic [LEN_W-1:0]    run_length_ff;
   logic [LEN_W-1:0]    run_length_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lispt_pkg::rsp_type  rsp_ff;
   lispt_pkg::rsp_type  rsp_in;

   logic                accept;
   logic                start;
   logic                any_ge;
   logic                full;
   logic                overflow;
   logic [EXT_W-1:0]    length_ext;

   lispt_pkg::link_type link_w [0:CAPACITY];
   logic [CAPACITY-1:0] ge_vec;
   logic [CAPACITY-1:0] write_vec;

   // The bottom of the row behaves like a live tail below every key.
   assign link_w[0] = '{valid: 1'b1, ge: 1'b0};

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      lispt_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock      (clock),
         .accept     (accept),
         .start      (start),
         .key        (req_item.value),
         .run_length (run_length_ff),
         .link_prev  (link_w[k]),
         .link_next  (link_w[k+1]),
         .write      (write_vec[k])
      );
      assign ge_vec[k] = link_w[k+1].ge;
   end

   // An item may enter whenever the output register is empty or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      // A first flag, or an empty store after reset, starts a new sequence.
      start    = req_item.first || (run_length_ff == '0);
      any_ge   = |ge_vec;
      full     = (run_length_ff == CAP_LEN);
      // No live tail reaches the key: append, or drop it when the store is full.
      overflow = !start && !any_ge && full;

      run_length_in = run_length_ff;
      if (accept) begin
         if (start) begin
            run_length_in = ONE_LEN;
         end else if (!any_ge && !full) begin
            run_length_in = run_length_ff + ONE_LEN;
         end
      end
   end

   always_comb begin
      length_ext = EXT_W'(run_length_in);
      rsp_in     = rsp_ff;
      if (accept) begin
         rsp_in.length   = length_ext[lispt_pkg::LENGTH_W-1:0];
         rsp_in.overflow = overflow;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_length_ff <= run_length_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The run length never passes the store size.
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= CAP_LEN)
      else $error("run length beyond capacity");

   // An item writes at most one tail cell.
   a_one_write : assert property (@(posedge clock) disable iff (reset)
      $onehot0(write_vec))
      else $error("more than one tail cell written");

   // A new sequence leaves exactly one live tail.
   a_start_len : assert property (@(posedge clock) disable iff (reset)
      accept && start |=> run_length_ff == ONE_LEN)
      else $error("new sequence did not reset the length");

   // A dropped append leaves the store full and unchanged in length.
   a_ovf_full : assert property (@(posedge clock) disable iff (reset)
      accept && overflow |=> run_length_ff == CAP_LEN && rsp_ff.overflow)
      else $error("overflow reported without a full store");

   // Compare results among live tails form a run of zeros then ones.
   a_monotone : assert property (@(posedge clock) disable iff (reset)
      (ge_vec & ~(ge_vec << 1)) == (ge_vec & ~(ge_vec << 1) & -(ge_vec & ~(ge_vec << 1))))
      else $error("tails out of order");

endmodule

`default_nettype wire

@@ hw/rtl/lispt_cell.sv @@
// One tail cell: holds one tail and decides locally whether the key lands here.
`default_nettype none

module lispt_cell #(
   parameter int CAPACITY = lispt_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  wire  logic                                clock,
   input  wire  logic                                accept,
   input  wire  logic                                start,
   input  wire  logic signed [lispt_pkg::VALUE_W-1:0] key,
   input  wire  logic [$clog2(CAPACITY+1)-1:0]       run_length,
   input  wire  lispt_pkg::link_type                 link_prev,
   output lispt_pkg::link_type                       link_next,
   output logic                                      write
);

   localparam int                LEN_W   = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0]  IDX     = LEN_W'(INDEX);
   localparam bit                IS_HEAD = (INDEX == 0);

   logic signed [lispt_pkg::VALUE_W-1:0] tail_ff;
   logic signed [lispt_pkg::VALUE_W-1:0] tail_in;
   logic                                 valid;
   logic                                 ge;
   logic                                 write_sel;

   always_comb begin
      valid = (run_length > IDX);
      ge    = valid && (tail_ff >= key);
      // Tails are strictly increasing, so the first tail at or above the key is the
      // one whose lower neighbor is below it, and the append slot is the first
      // empty cell above a live one when no live tail reaches the key.
      if (start) begin
         write_sel = IS_HEAD;
      end else begin
         write_sel = (ge && !link_prev.ge) || (!valid && link_prev.valid && !link_prev.ge);
      end
      write           = accept && write_sel;
      tail_in         = write ? key : tail_ff;
      link_next.valid = valid;
      link_next.ge    = ge;
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire
